// ===== rtl/rscs_pkg.sv =====
// ============================================================================
// rscs_pkg
// Shared types and constants for the rotated sorted ceiling search core:
// payload structs, register indexes, operation codes and the control
// bundles between the controller and the datapath.
// ============================================================================
package rscs_pkg;

  // Field and storage sizes
  localparam int VALUE_BITS    = 50;
  localparam int DEPTH_DEFAULT = 1024;
  localparam int COUNT_BITS    = 11;
  localparam int ROT_BITS      = 10;
  localparam int POS_BITS      = 11;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 11;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ELEMENT_COUNT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROTATE_AMOUNT = 1'b1;

  // Input beat
  typedef struct packed {
    logic                  operation;
    logic [VALUE_BITS-1:0] value;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic                found;
    logic [POS_BITS-1:0] position;
  } out_item_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic q_start;
    logic ld_write;
    logic rd_issue;
    logic s1_update;
    logic s2_init;
    logic s2_update;
    logic out_load;
    logic out_found;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic lo_lt_hi;
    logic lo_ge_n;
    logic rem_busy;
  } dp_stat_t;

endpackage

// ===== rtl/rscs_rem.sv =====
// ============================================================================
// rscs_rem
// Restoring remainder unit: one quotient bit per cycle, giving the rotation
// amount modulo the searched element count.
// ============================================================================
module rscs_rem import rscs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ROT_BITS-1:0]   dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  busy,
  output logic [COUNT_BITS-1:0] remainder
);

  localparam int STEP_BITS = $clog2(ROT_BITS + 1);

  logic [ROT_BITS-1:0]   dvd_r;
  logic [COUNT_BITS-1:0] dvs_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [COUNT_BITS-1:0] rem_nxt;
  logic [STEP_BITS-1:0]  step_r;
  logic                  busy_r;
  logic [COUNT_BITS:0]   trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_r, dvd_r[ROT_BITS-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = COUNT_BITS'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = COUNT_BITS'(trial);
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_BITS'(ROT_BITS);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == STEP_BITS'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign busy      = busy_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/rscs_dp.sv =====
// ============================================================================
// rscs_dp
// Datapath: configuration registers, element store, load pointer, search
// bounds, rotated position arithmetic and the result register.
// ============================================================================
module rscs_dp import rscs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  in_item_t                 in_data,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  output out_item_t                out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;

  logic [COUNT_BITS-1:0] cnt_cfg_r;
  logic [ROT_BITS-1:0]   rot_cfg_r;
  logic [PW-1:0]         ptr_r;
  logic [VALUE_BITS-1:0] store_mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic [VALUE_BITS-1:0] q_r;
  logic [VALUE_BITS-1:0] hit_r;
  logic [COUNT_BITS-1:0] n_cap;
  logic [COUNT_BITS-1:0] n_r;
  logic [COUNT_BITS-1:0] lo_r, lo_nxt;
  logic [COUNT_BITS-1:0] hi_r, hi_nxt;
  logic [COUNT_BITS-1:0] mid_r;
  logic [COUNT_BITS-1:0] first_r;
  logic [COUNT_BITS-1:0] span;
  logic [COUNT_BITS-1:0] mid;
  logic [COUNT_BITS-1:0] rot_mod;
  logic [COUNT_BITS-1:0] last;
  logic [COUNT_BITS:0]   wrap_sum;
  logic [COUNT_BITS-1:0] gap;
  logic [POS_BITS-1:0]   pos_calc;
  logic                  in_run;
  logic                  rem_busy;
  logic                  ptr_free;
  out_item_t             out_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_cfg_r <= COUNT_BITS'(1);
      rot_cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ELEMENT_COUNT: cnt_cfg_r <= cfg_data;
        REG_ROTATE_AMOUNT: rot_cfg_r <= ROT_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // Clamp the searched count to the store depth
  always_comb begin
    if (int'(cnt_cfg_r) > DEPTH) begin
      n_cap = COUNT_BITS'(DEPTH);
    end else begin
      n_cap = cnt_cfg_r;
    end
  end

  // Load pointer, stops at the store depth
  assign ptr_free = ptr_r < PW'(DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.ld_write && ptr_free) begin
      ptr_r <= ptr_r + 1'b1;
    end
  end

  // Midpoint, rounded down
  assign span = hi_r - lo_r;
  assign mid  = lo_r + (span >> 1);

  // Element store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.ld_write && ptr_free) begin
      store_mem[ptr_r[AW-1:0]] <= in_data.value;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= store_mem[AW'(mid)];
    end
  end

  // Search bounds
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    priority if (cmd.q_start) begin
      lo_nxt = '0;
      hi_nxt = n_cap;
    end else if (cmd.s1_update) begin
      if (rd_data_r < q_r) begin
        lo_nxt = mid_r + 1'b1;
      end else begin
        hi_nxt = mid_r;
      end
    end else if (cmd.s2_init) begin
      hi_nxt = n_r;
    end else if (cmd.s2_update) begin
      if (rd_data_r <= hit_r) begin
        lo_nxt = mid_r + 1'b1;
      end else begin
        hi_nxt = mid_r;
      end
    end else begin
      lo_nxt = lo_r;
    end
  end

  // Query operands and search registers
  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.q_start) begin
      q_r <= in_data.value;
      n_r <= n_cap;
    end
    if (cmd.rd_issue) begin
      mid_r <= mid;
    end
    // The last element at or above the query is the ceiling value
    if (cmd.s1_update && !(rd_data_r < q_r)) begin
      hit_r <= rd_data_r;
    end
    if (cmd.s2_init) begin
      first_r <= lo_r;
    end
  end

  // Rotation modulo the element count
  rscs_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.q_start),
    .dividend  (rot_cfg_r),
    .divisor   (n_cap),
    .busy      (rem_busy),
    .remainder (rot_mod)
  );

  // Rotated position: first rank if the rotation start lies in the run
  always_comb begin
    if (lo_r > first_r) begin
      last = lo_r - 1'b1;
    end else begin
      last = first_r;
    end
    in_run   = (first_r <= rot_mod) && (rot_mod <= last);
    wrap_sum = {1'b0, first_r} + {1'b0, n_r} - {1'b0, rot_mod};
    if (first_r >= rot_mod) begin
      gap = first_r - rot_mod;
    end else begin
      gap = COUNT_BITS'(wrap_sum);
    end
    if (in_run) begin
      pos_calc = POS_BITS'(1);
    end else begin
      pos_calc = POS_BITS'(gap + 1'b1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.found <= cmd.out_found;
      out_r.position <= cmd.out_found ? pos_calc : '0;
    end
  end

  assign out_data      = out_r;
  assign stat.lo_lt_hi = lo_r < hi_r;
  assign stat.lo_ge_n  = lo_r >= n_r;
  assign stat.rem_busy = rem_busy;

endmodule

// ===== rtl/rscs_ctrl.sv =====
// ============================================================================
// rscs_ctrl
// Controller: input handshake, the two binary search loops and the result
// valid flag.
// ============================================================================
module rscs_ctrl import rscs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_S1_RD  = 7'b0000010,
    ST_S1_CMP = 7'b0000100,
    ST_S2_RD  = 7'b0001000,
    ST_S2_CMP = 7'b0010000,
    ST_FIN    = 7'b0100000,
    ST_NONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_QUERY) begin
            cmd.q_start = 1'b1;
            state_nxt   = ST_S1_RD;
          end else begin
            cmd.ld_write = 1'b1;
          end
        end
      end
      ST_S1_RD: begin
        if (stat.lo_lt_hi) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_S1_CMP;
        end else if (stat.lo_ge_n) begin
          state_nxt = ST_NONE;
        end else begin
          cmd.s2_init = 1'b1;
          state_nxt   = ST_S2_RD;
        end
      end
      ST_S1_CMP: begin
        cmd.s1_update = 1'b1;
        state_nxt     = ST_S1_RD;
      end
      ST_S2_RD: begin
        if (stat.lo_lt_hi) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_S2_CMP;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_S2_CMP: begin
        cmd.s2_update = 1'b1;
        state_nxt     = ST_S2_RD;
      end
      ST_FIN: begin
        if (!stat.rem_busy && out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_found = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_NONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the result beat until it is taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/rotated_sorted_ceiling_search_core.sv =====
// ============================================================================
// rotated_sorted_ceiling_search_core
// A load beat is taken while idle. A hit runs both search loops before its result
// beat, a miss only the first; each loop has at most ceil(log2(n+1)) steps.
// Each search step is one store read plus one compare.
// The next beat is taken as soon as the result sits in the output register.
// Synchronous active-low reset clears control state, load pointer and config.
// ============================================================================
module rotated_sorted_ceiling_search_core import rscs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  rscs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store and arithmetic
  rscs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/rscs_checker.sv =====
// ============================================================================
// rscs_checker
// Port-level checks for the rotated sorted ceiling search core, bound to the
// top level.
// ============================================================================
module rscs_checker import rscs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Position is nonzero exactly when found
  a_pos_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.found == (out_data.position != '0)))
    else $error("position does not match found flag");

  // A query blocks input and cannot answer in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.operation == OP_QUERY
    |=> in_stall && !$rose(out_valid))
    else $error("query not held in search");

endmodule

bind rotated_sorted_ceiling_search_core rscs_checker u_rscs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/tb_rotated_sorted_ceiling_search_core.sv =====
// ============================================================================
// tb_rotated_sorted_ceiling_search_core
// Self-checking bench for the ceiling search core. A directed table covers
// reset defaults, field extremes, zero counts, large rotation, loads past
// the searched range and an unsorted entry. Random phases then append a
// mostly non-decreasing sequence, retune both registers while idle and mix
// loads with queries. A final part runs back to back with no idling.
// Every result beat is checked against a typed answer or a local ceiling predictor.
// ============================================================================
module tb_rotated_sorted_ceiling_search_core;
  import rscs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int NUM_PHASES = 8;
  localparam int BLOCK_LATENCY = 60;
  localparam int HOLD_CYCLES = 300;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  typedef enum bit {ROW_BEAT, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic                  op;
    logic [VALUE_BITS-1:0] value;
    logic [10:0]           cnt;
    logic [10:0]           rot;
    bit                    typed;
    out_item_t             ans;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_data;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // Predictor state: shadow of the store, load pointer and both registers
  logic [VALUE_BITS-1:0] seq_mem [DEPTH];
  int                    seq_fill = 0;
  logic [10:0]           cnt_reg = 11'd1;
  logic [9:0]            rot_reg = 10'd0;
  logic [VALUE_BITS-1:0] run_val = 20;

  out_item_t answer_q [$];
  dir_row_t  plan [$];
  int        err_count = 0;
  bit        quiet = 1'b0;
  bit        hold_req = 1'b0;

  rotated_sorted_ceiling_search_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Lower bound, then end of the equal run, then rotate the position
  function automatic out_item_t ceiling_answer(logic [VALUE_BITS-1:0] q);
    out_item_t             r;
    int                    n, lo, hi, mid, first, last, k, pos;
    logic [VALUE_BITS-1:0] hit;
    r = '0;
    n = (int'(cnt_reg) > DEPTH) ? DEPTH : int'(cnt_reg);
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (seq_mem[mid] < q) lo = mid + 1;
      else hi = mid;
    end
    if (lo >= n) return r;
    first = lo;
    hit = seq_mem[first];
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (seq_mem[mid] <= hit) lo = mid + 1;
      else hi = mid;
    end
    last = (lo > first) ? lo - 1 : first;
    k = int'(rot_reg) % n;
    if (first <= k && k <= last) pos = 1;
    else pos = ((first + n - k) % n) + 1;
    r.found = 1'b1;
    r.position = pos[POS_BITS-1:0];
    return r;
  endfunction

  function automatic logic [VALUE_BITS-1:0] rand_value();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[VALUE_BITS-1:0];
  endfunction

  // Mostly extend the non-decreasing run; now and then drop in noise
  function automatic logic [VALUE_BITS-1:0] next_load_value();
    logic [63:0] step, sum;
    int          r;
    r = $urandom_range(0, 15);
    if (r == 0) return rand_value();
    if (r < 11) step = 64'($urandom_range(0, 2));
    else step = 64'(rand_value() >> $urandom_range(12, 30));
    sum = 64'(run_val) + step;
    run_val = (sum > 64'(VALUE_MAX)) ? VALUE_MAX : sum[VALUE_BITS-1:0];
    return run_val;
  endfunction

  // Aim queries at stored values, their neighbors and the extremes
  function automatic logic [VALUE_BITS-1:0] next_query_value();
    int n, i;
    n = (int'(cnt_reg) > DEPTH) ? DEPTH : int'(cnt_reg);
    if (n == 0) return ($urandom_range(0, 1) == 0) ? VALUE_MAX : rand_value();
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return VALUE_MAX;
      2, 3: return seq_mem[i];
      4: return seq_mem[i] + 1'b1;
      5: return seq_mem[i] - 1'b1;
      6: return rand_value() >> $urandom_range(0, VALUE_BITS - 1);
      default: return seq_mem[n-1] + 1'b1;
    endcase
  endfunction

  function automatic in_item_t make_beat(logic op, logic [VALUE_BITS-1:0] v);
    in_item_t b;
    b.operation = op;
    b.value = v;
    return b;
  endfunction

  function automatic dir_row_t beat_row(logic op, logic [VALUE_BITS-1:0] v, bit typed,
                                        logic found, logic [POS_BITS-1:0] pos);
    dir_row_t r;
    r.kind = ROW_BEAT;
    r.op = op;
    r.value = v;
    r.cnt = '0;
    r.rot = '0;
    r.typed = typed;
    r.ans.found = found;
    r.ans.position = pos;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [10:0] cnt, logic [10:0] rot);
    dir_row_t r;
    r = beat_row(OP_LOAD, '0, 1'b0, 1'b0, '0);
    r.kind = ROW_CONFIG;
    r.cnt = cnt;
    r.rot = rot;
    return r;
  endfunction

  task automatic note_mismatch(string what, longint got, longint want);
    err_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Offer one beat, hold it until taken, then record what it implies
  task automatic drive_beat(in_item_t beat, bit typed, out_item_t typed_ans);
    in_data <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (beat.operation == OP_QUERY) begin
      answer_q.push_back(typed ? typed_ans : ceiling_answer(beat.value));
    end else if (seq_fill < DEPTH) begin
      seq_mem[seq_fill] = beat.value;
      seq_fill++;
    end
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Drain all results and let a trailing load finish
  task automatic settle();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk);
    repeat (BLOCK_LATENCY) @(negedge clk);
  endtask

  task automatic set_config(logic [10:0] cnt, logic [10:0] rot);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_ELEMENT_COUNT;
    cfg_data <= cnt;
    cnt_reg = cnt;
    @(negedge clk);
    cfg_index <= REG_ROTATE_AMOUNT;
    cfg_data <= rot;
    rot_reg = rot[9:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(logic [10:0] cnt, logic [10:0] rot, int beats, int load_pct);
    set_config(cnt, rot);
    repeat (beats) begin
      if ($urandom_range(0, 99) < load_pct)
        drive_beat(make_beat(OP_LOAD, next_load_value()), 1'b0, '0);
      else
        drive_beat(make_beat(OP_QUERY, next_query_value()), 1'b0, '0);
    end
  endtask

  // Check each accepted result beat against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        note_mismatch("unexpected result beat, position", out_data.position, 0);
      end else begin
        want = answer_q.pop_front();
        if (out_data.found !== want.found)
          note_mismatch("found", out_data.found, want.found);
        if (out_data.position !== want.position)
          note_mismatch("position", out_data.position, want.position);
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Stop a hung run
  initial begin
    #18_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [10:0] cnt, rot;
    int          n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    // Reset defaults: one element searched, no rotation
    plan.push_back(beat_row(OP_LOAD, 5, 1'b0, 1'b0, 0));
    plan.push_back(beat_row(OP_QUERY, 5, 1'b1, 1'b1, 1));
    plan.push_back(beat_row(OP_QUERY, 0, 1'b1, 1'b1, 1));
    plan.push_back(beat_row(OP_QUERY, 6, 1'b1, 1'b0, 0));
    plan.push_back(beat_row(OP_QUERY, VALUE_MAX, 1'b1, 1'b0, 0));
    // Runs of equal values, rotation landing inside a run
    plan.push_back(beat_row(OP_LOAD, 5, 1'b0, 1'b0, 0));
    plan.push_back(beat_row(OP_LOAD, 9, 1'b0, 1'b0, 0));
    plan.push_back(beat_row(OP_LOAD, 9, 1'b0, 1'b0, 0));
    plan.push_back(beat_row(OP_LOAD, 20, 1'b0, 1'b0, 0));
    plan.push_back(cfg_row(5, 3));
    plan.push_back(beat_row(OP_QUERY, 9, 1'b0, 1'b0, 0));
    plan.push_back(beat_row(OP_QUERY, 0, 1'b0, 1'b0, 0));
    plan.push_back(beat_row(OP_QUERY, 21, 1'b1, 1'b0, 0));
    plan.push_back(beat_row(OP_QUERY, VALUE_MAX, 1'b1, 1'b0, 0));
    // Zero count answers nothing
    plan.push_back(cfg_row(0, 0));
    plan.push_back(beat_row(OP_QUERY, 5, 1'b1, 1'b0, 0));
    // Rotation far above the count wraps
    plan.push_back(cfg_row(5, 1023));
    plan.push_back(beat_row(OP_QUERY, 20, 1'b0, 1'b0, 0));
    plan.push_back(beat_row(OP_QUERY, 10, 1'b0, 1'b0, 0));
    // Stored values past the count stay out of the search
    plan.push_back(cfg_row(3, 2));
    plan.push_back(beat_row(OP_QUERY, 20, 1'b1, 1'b0, 0));
    // A smaller value after the run breaks the ordering
    plan.push_back(beat_row(OP_LOAD, 1, 1'b0, 1'b0, 0));
    plan.push_back(cfg_row(6, 5));
    plan.push_back(beat_row(OP_QUERY, 2, 1'b0, 1'b0, 0));
    plan.push_back(beat_row(OP_QUERY, 1, 1'b0, 1'b0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CONFIG)
        set_config(plan[i].cnt, plan[i].rot);
      else
        drive_beat(make_beat(plan[i].op, plan[i].value), plan[i].typed, plan[i].ans);
    end

    // Random phases: grow the sequence, retune, then mix loads and queries
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      repeat ($urandom_range(60, 80))
        drive_beat(make_beat(OP_LOAD, next_load_value()), 1'b0, '0);
      case ($urandom_range(0, 7))
        0: cnt = 0;
        1: cnt = 1;
        2: cnt = 11'(seq_fill);
        default: cnt = 11'($urandom_range(1, seq_fill));
      endcase
      n = int'(cnt);
      case ($urandom_range(0, 5))
        0: rot = 0;
        1: rot = (n > 0) ? 11'(n - 1) : 11'd0;
        2: rot = 11'($urandom_range(0, 2047));
        default: rot = (n > 0) ? 11'($urandom_range(0, n - 1)) : 11'd0;
      endcase
      // Hold off the result side once so the core backs up into its input
      if (ph == 3) begin
        settle();
        hold_req = 1'b1;
      end
      random_phase(cnt, rot, 30, 20);
    end

    // Last part: no idling; search the whole loaded range back to back
    settle();
    quiet = 1'b1;
    random_phase(11'(seq_fill), 11'($urandom_range(0, 2047)), 20, 20);
    random_phase(11'(seq_fill), 11'(seq_fill + 1), 20, 0);

    settle();
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
